>>> rtl/mexp_pkg.sv
// shared constants and types for the modular exponentiation block
package mexp_pkg;

    // width of every payload field on the ports
    localparam int FIELD_WIDTH = 32;

    // default internal operand width
    localparam int OPERAND_WIDTH_DEF = 32;

    // status that the modular multiplier reports to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

>>> rtl/mexp_modmul.sv
// bit-serial modular multiplier: one bit of the multiplier per cycle, msb first
module mexp_modmul #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] mult_a,
    input  logic [OPERAND_WIDTH-1:0] mult_b,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output mexp_pkg::mm_status_t     status,
    output logic [OPERAND_WIDTH-1:0] product
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg,    a_next;
    logic [W-1:0]  b_reg,    b_next;
    logic [W-1:0]  m_reg,    m_next;
    logic [W-1:0]  acc_reg,  acc_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // one horner step: acc = (2*acc + bit*b) mod m, with acc, b < m
    logic [W+1:0] sum;
    logic [W+2:0] diff1;
    logic [W+2:0] diff2;
    logic [W-1:0] step_val;

    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0} + (a_reg[W-1] ? {2'b00, b_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, m_reg};
        diff2 = {1'b0, sum} - {2'b00, m_reg, 1'b0};
        priority if (!diff2[W+2])
        begin
            step_val = diff2[W-1:0];
        end
        else if (!diff1[W+2])
        begin
            step_val = diff1[W-1:0];
        end
        else
        begin
            step_val = sum[W-1:0];
        end
    end

    // sequencing of the bit steps
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = mult_a;
            b_next    = mult_b;
            m_next    = modulus;
            acc_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            m_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            m_reg    <= m_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

>>> rtl/modular_exponentiation_32.sv
// top level: base^exponent mod modulus by right-to-left square-and-multiply
//
// input channel: valid/stall with base_value, exponent_value, modulus_value.
// a beat is taken when valid is high and stall is low; stall stays high from
// the cycle after an accepted beat until the result is in the output register.
// output channel: result_valid/result_stall with power_result, held in a
// register so the receiver may stall for as long as it likes.
// a zero base, zero modulus or zero exponent skips the multipliers and goes
// straight to the finish state. otherwise the base is first reduced mod the
// modulus, then each exponent bit up to the highest set one takes a square
// and a multiply, run side by side on two bit-serial modular multipliers.
// the block handles one beat at a time.
// when a result is done while the previous one is still stalled, the block
// waits with stall high until the output register frees up.
// reset clears the sequencer and the output valid; no beat is in flight.
module modular_exponentiation_32 #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid,
    output logic                             stall,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] base_value,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] exponent_value,
    input  logic [mexp_pkg::FIELD_WIDTH-1:0] modulus_value,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [mexp_pkg::FIELD_WIDTH-1:0] power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int FW = mexp_pkg::FIELD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_FINISH
    } state_t;

    state_t        state_reg,  state_next;
    logic [W-1:0]  mod_reg,    mod_next;
    logic [W-1:0]  expo_reg,   expo_next;
    logic [W-1:0]  acc_reg,    acc_next;
    logic [W-1:0]  pw_reg,     pw_next;
    logic [W-1:0]  fin_reg,    fin_next;
    logic [FW-1:0] result_reg, result_next;
    logic          rvalid_reg, rvalid_next;

    logic [W-1:0] base_op;
    logic [W-1:0] expo_op;
    logic [W-1:0] mod_op;
    logic [W-1:0] one_red;
    logic         accept;
    logic         special;

    logic                 ua_start;
    logic                 ub_start;
    logic [W-1:0]         ua_a;
    logic [W-1:0]         ua_b;
    logic [W-1:0]         mod_sel;
    mexp_pkg::mm_status_t ua_status;
    mexp_pkg::mm_status_t ub_status;
    logic [W-1:0]         ua_product;
    logic [W-1:0]         ub_product;

    // operands at the internal width
    assign base_op = W'(base_value);
    assign expo_op = W'(exponent_value);
    assign mod_op  = W'(modulus_value);
    assign one_red = (mod_op == W'(1)) ? '0 : W'(1);

    assign stall   = (state_reg != S_IDLE);
    assign accept  = valid && !stall;
    assign special = (base_op == '0) || (mod_op == '0) || (expo_op == '0);

    // operand selection for the two multipliers
    assign ua_start = (accept && !special) || ((state_reg == S_STEP) && (expo_reg != '0));
    assign ub_start = (state_reg == S_STEP) && (expo_reg != '0);
    assign ua_a     = (state_reg == S_IDLE) ? base_op : acc_reg;
    assign ua_b     = (state_reg == S_IDLE) ? one_red : pw_reg;
    assign mod_sel  = (state_reg == S_IDLE) ? mod_op : mod_reg;

    // multiplier a: base reduction, then accumulator times running power
    mexp_modmul #(
        .OPERAND_WIDTH(W)
    ) u_mul_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ua_start),
        .mult_a  (ua_a),
        .mult_b  (ua_b),
        .modulus (mod_sel),
        .status  (ua_status),
        .product (ua_product)
    );

    // multiplier b: squaring of the running power
    mexp_modmul #(
        .OPERAND_WIDTH(W)
    ) u_mul_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ub_start),
        .mult_a  (pw_reg),
        .mult_b  (pw_reg),
        .modulus (mod_reg),
        .status  (ub_status),
        .product (ub_product)
    );

    // sequencer and output register
    always_comb
    begin
        state_next  = state_reg;
        mod_next    = mod_reg;
        expo_next   = expo_reg;
        acc_next    = acc_reg;
        pw_next     = pw_reg;
        fin_next    = fin_reg;
        result_next = result_reg;
        rvalid_next = rvalid_reg;

        // output beat taken
        if (rvalid_reg && !result_stall)
        begin
            rvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mod_next  = mod_op;
                    expo_next = expo_op;
                    acc_next  = one_red;
                    if ((base_op == '0) || (mod_op == '0))
                    begin
                        fin_next   = '0;
                        state_next = S_FINISH;
                    end
                    else if (expo_op == '0)
                    begin
                        fin_next   = W'(1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (ua_status.done)
                begin
                    pw_next    = ua_product;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (expo_reg == '0)
                begin
                    fin_next   = acc_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (ub_status.done)
                begin
                    if (expo_reg[0])
                    begin
                        acc_next = ua_product;
                    end
                    pw_next    = ub_product;
                    expo_next  = {1'b0, expo_reg[W-1:1]};
                    state_next = S_STEP;
                end
            end
            S_FINISH:
            begin
                if (!rvalid_reg || !result_stall)
                begin
                    result_next = FW'(fin_reg);
                    rvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mod_reg    <= '0;
            expo_reg   <= '0;
            acc_reg    <= '0;
            pw_reg     <= '0;
            fin_reg    <= '0;
            result_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mod_reg    <= mod_next;
            expo_reg   <= expo_next;
            acc_reg    <= acc_next;
            pw_reg     <= pw_next;
            fin_reg    <= fin_next;
            result_reg <= result_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign result_valid = rvalid_reg;
    assign power_result = result_reg;

endmodule

>>> rtl/mexp_checker.sv
// port-level checks for the modular exponentiation block, bound to the top level
module mexp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             stall,
    input logic [mexp_pkg::FIELD_WIDTH-1:0] base_value,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [mexp_pkg::FIELD_WIDTH-1:0] power_result
);

    // one beat at a time: an accepted beat blocks the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !stall |=> stall)
        else $error("input not blocked after an accepted beat");

    // a new result appears only as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !stall)
        else $error("result raised while the input is still blocked");

    // zero base short-cuts through the finish state to a zero result
    a_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !stall && (base_value == '0) && !result_valid
        |=> ##1 result_valid && (power_result == '0))
        else $error("zero base did not give a prompt zero result");

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(power_result))
        else $error("result payload changed while stalled");

endmodule

bind modular_exponentiation_32 mexp_checker u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (valid),
    .stall        (stall),
    .base_value   (base_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .power_result (power_result)
);
